// ===== rtl/arq_pkg.sv =====
// ----------------------------------------------------------------------------
// arq_pkg
// Shared types, codes and constants of the ARQ sender retransmit tracker.
// ----------------------------------------------------------------------------
package arq_pkg;

    localparam int SEQ_W     = 16;
    localparam int TIME_W    = 32;
    localparam int TIMEOUT_W = 8;
    localparam int FUNC_W    = 2;
    localparam int KIND_W    = 3;

    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DEF_SLOT_COUNT  = 16;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 8'd2;

    // Register indexes of the configuration port.
    localparam logic REG_TIMEOUT = 1'b0;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_SUBMIT = 2'd0,
        FUNC_ACK    = 2'd1,
        FUNC_TICK   = 2'd2
    } func_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_ACCEPTED    = 3'd0,
        KIND_FULL        = 3'd1,
        KIND_TRANSMIT    = 3'd2,
        KIND_RETRANSMIT  = 3'd3,
        KIND_ACK_CLEARED = 3'd4,
        KIND_DUP_ACK     = 3'd5,
        KIND_TICK_DONE   = 3'd6
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SUB_EMIT,
        ST_ACK_RD,
        ST_ACK_EV,
        ST_ACK_EMIT,
        ST_RT_RD,
        ST_RT_EV,
        ST_TX_CHK,
        ST_TX_EV,
        ST_DONE_EMIT
    } state_t;

    typedef struct packed {
        logic [SEQ_W-1:0]  seq;
        logic [TIME_W-1:0] stamp;
    } slot_entry_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic valid_set;
        logic valid_clr;
    } slot_ctl_t;

    typedef struct packed {
        logic push;
        logic rd_en;
        logic pop;
    } queue_ctl_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

endpackage

// ===== rtl/arq_queue.sv =====
// ----------------------------------------------------------------------------
// arq_queue
// FIFO of issued sequence numbers waiting for a free slot, held in a RAM.
// ----------------------------------------------------------------------------
module arq_queue #(
    parameter int QUEUE_DEPTH = arq_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  arq_pkg::queue_ctl_t      ctl,
    input  logic [arq_pkg::SEQ_W-1:0] push_data,
    output logic [arq_pkg::SEQ_W-1:0] head_data,
    output arq_pkg::queue_stat_t     stat
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [arq_pkg::SEQ_W-1:0] mem [QUEUE_DEPTH];
    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic [CW-1:0] count_reg, count_next;
    logic [arq_pkg::SEQ_W-1:0] rd_data_reg;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (ctl.push)
        begin
            tail_next  = (tail_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
            count_next = count_reg + 1'b1;
        end
        else if (ctl.pop)
        begin
            head_next  = (head_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.push)
        begin
            mem[tail_reg] <= push_data;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[head_reg];
        end
    end

    assign head_data  = rd_data_reg;
    assign stat.full  = (count_reg == CW'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);

endmodule

// ===== rtl/arq_slots.sv =====
// ----------------------------------------------------------------------------
// arq_slots
// Retransmit slot table: number and stamp in a RAM, valid bits in flops.
// ----------------------------------------------------------------------------
module arq_slots #(
    parameter int SLOT_COUNT = arq_pkg::DEF_SLOT_COUNT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  arq_pkg::slot_ctl_t            ctl,
    input  logic [$clog2(SLOT_COUNT)-1:0] addr,
    input  arq_pkg::slot_entry_t          wr_data,
    output arq_pkg::slot_entry_t          rd_data,
    output logic [SLOT_COUNT-1:0]         valid
);

    arq_pkg::slot_entry_t mem [SLOT_COUNT];
    arq_pkg::slot_entry_t rd_data_reg;
    logic [SLOT_COUNT-1:0] valid_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (ctl.valid_set)
        begin
            valid_reg[addr] <= 1'b1;
        end
        else if (ctl.valid_clr)
        begin
            valid_reg[addr] <= 1'b0;
        end
    end

    assign rd_data = rd_data_reg;
    assign valid   = valid_reg;

endmodule

// ===== rtl/arq_sender_tracker.sv =====
// ----------------------------------------------------------------------------
// arq_sender_tracker
// Sender-side retransmit tracker of a selective-repeat ARQ scheme.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake                tdata          tuser
// s_axis    in         tvalid/tready            ack_seq, now   func
// m_axis    out        tvalid/tready, tlast     seq            kind
// apb       in/out     psel/penable, pready=1   timeout_ticks  -
//
// One request is taken at a time; the block accepts it only in its idle state.
// A submit goes straight to its emitting state; an ack or a tick scans the slots
// one index at a time. Each slot step goes through the single port of the
// slot RAM and, for a transmit, the queue RAM, each with a registered read.
// Reset clears the counters and the slot valid bits at once, so no clearing
// pass is needed. A stalled result register holds the scan at the emitting
// step; the next request may still be taken while the last result of the
// previous one waits for m_axis_tready.
// ----------------------------------------------------------------------------
module arq_sender_tracker #(
    parameter int QUEUE_DEPTH = arq_pkg::DEF_QUEUE_DEPTH,
    parameter int SLOT_COUNT  = arq_pkg::DEF_SLOT_COUNT
) (
    input  logic        clk,
    input  logic        rst_n,
    // Request stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // [15:0] ack_seq, [47:16] now
    input  logic [1:0]  s_axis_tuser,   // [1:0] func
    // Result stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] seq
    output logic [2:0]  m_axis_tuser,   // [2:0] kind
    output logic        m_axis_tlast,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int SW = $clog2(SLOT_COUNT);
    localparam int IW = $clog2(SLOT_COUNT + 1);

    // ------------------------------------------------------------------
    // Configuration register. Byte address 0 holds timeout_ticks; the
    // register index is address bit 2.
    // ------------------------------------------------------------------
    logic [arq_pkg::TIMEOUT_W-1:0] timeout_reg;
    logic cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= arq_pkg::TIMEOUT_RESET;
        end
        else if (cfg_wr && (paddr[2] == arq_pkg::REG_TIMEOUT))
        begin
            timeout_reg <= pwdata[arq_pkg::TIMEOUT_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == arq_pkg::REG_TIMEOUT)
        begin
            prdata = {{(32 - arq_pkg::TIMEOUT_W){1'b0}}, timeout_reg};
        end
    end

    // ------------------------------------------------------------------
    // Control state and captured request fields.
    // ------------------------------------------------------------------
    arq_pkg::state_t state_reg, state_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [arq_pkg::SEQ_W-1:0] next_seq_reg, next_seq_next;
    logic found_reg, found_next;
    logic [arq_pkg::SEQ_W-1:0] ack_reg;
    logic [arq_pkg::TIME_W-1:0] now_reg;

    logic in_acc;
    assign s_axis_tready = (state_reg == arq_pkg::ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    // Result register.
    logic out_valid_reg;
    logic [arq_pkg::SEQ_W-1:0] out_seq_reg;
    arq_pkg::kind_t out_kind_reg;
    logic out_last_reg;
    logic out_free;

    assign out_free = !out_valid_reg || m_axis_tready;

    logic emit;
    arq_pkg::kind_t emit_kind;
    logic [arq_pkg::SEQ_W-1:0] emit_seq;

    // Sub-block connections.
    arq_pkg::slot_ctl_t   slot_ctl;
    arq_pkg::slot_entry_t slot_wr;
    arq_pkg::slot_entry_t slot_rd;
    logic [SLOT_COUNT-1:0] slot_valid;
    logic [SW-1:0] slot_idx;

    arq_pkg::queue_ctl_t  q_ctl;
    arq_pkg::queue_stat_t q_stat;
    logic [arq_pkg::SEQ_W-1:0] q_push_data;
    logic [arq_pkg::SEQ_W-1:0] q_head;

    logic idx_done;
    logic [arq_pkg::TIME_W-1:0] age;
    logic expired;

    assign slot_idx = idx_reg[SW-1:0];
    assign idx_done = (idx_reg == IW'(SLOT_COUNT));
    // Wrap-safe age of the entry just read.
    assign age      = now_reg - slot_rd.stamp;
    assign expired  = (age >= {{(arq_pkg::TIME_W - arq_pkg::TIMEOUT_W){1'b0}}, timeout_reg});

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        next_seq_next = next_seq_reg;
        found_next    = found_reg;
        emit          = 1'b0;
        emit_kind     = arq_pkg::KIND_TICK_DONE;
        emit_seq      = '0;
        slot_ctl      = '0;
        slot_wr.seq   = slot_rd.seq;
        slot_wr.stamp = now_reg;
        q_ctl         = '0;
        q_push_data   = next_seq_reg + 1'b1;

        unique case (state_reg)
            arq_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    idx_next   = '0;
                    found_next = 1'b0;
                    case (arq_pkg::func_t'(s_axis_tuser))
                        arq_pkg::FUNC_SUBMIT: state_next = arq_pkg::ST_SUB_EMIT;
                        arq_pkg::FUNC_ACK:    state_next = arq_pkg::ST_ACK_RD;
                        arq_pkg::FUNC_TICK:   state_next = arq_pkg::ST_RT_RD;
                        default:              state_next = arq_pkg::ST_IDLE;
                    endcase
                end
            end

            arq_pkg::ST_SUB_EMIT:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    if (q_stat.full)
                    begin
                        emit_kind = arq_pkg::KIND_FULL;
                    end
                    else
                    begin
                        emit_kind     = arq_pkg::KIND_ACCEPTED;
                        emit_seq      = q_push_data;
                        q_ctl.push    = 1'b1;
                        next_seq_next = q_push_data;
                    end
                    state_next = arq_pkg::ST_IDLE;
                end
            end

            arq_pkg::ST_ACK_RD:
            begin
                if (idx_done)
                begin
                    state_next = arq_pkg::ST_ACK_EMIT;
                end
                else if (slot_valid[slot_idx])
                begin
                    slot_ctl.rd_en = 1'b1;
                    state_next     = arq_pkg::ST_ACK_EV;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            arq_pkg::ST_ACK_EV:
            begin
                if (slot_rd.seq == ack_reg)
                begin
                    slot_ctl.valid_clr = 1'b1;
                    found_next         = 1'b1;
                    state_next         = arq_pkg::ST_ACK_EMIT;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = arq_pkg::ST_ACK_RD;
                end
            end

            arq_pkg::ST_ACK_EMIT:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    emit_kind  = found_reg ? arq_pkg::KIND_ACK_CLEARED : arq_pkg::KIND_DUP_ACK;
                    emit_seq   = ack_reg;
                    state_next = arq_pkg::ST_IDLE;
                end
            end

            arq_pkg::ST_RT_RD:
            begin
                if (idx_done)
                begin
                    idx_next   = '0;
                    state_next = arq_pkg::ST_TX_CHK;
                end
                else if (slot_valid[slot_idx])
                begin
                    slot_ctl.rd_en = 1'b1;
                    state_next     = arq_pkg::ST_RT_EV;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            arq_pkg::ST_RT_EV:
            begin
                if (!expired)
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = arq_pkg::ST_RT_RD;
                end
                else if (out_free)
                begin
                    // Retransmit and restamp the entry in place.
                    emit           = 1'b1;
                    emit_kind      = arq_pkg::KIND_RETRANSMIT;
                    emit_seq       = slot_rd.seq;
                    slot_ctl.wr_en = 1'b1;
                    idx_next       = idx_reg + 1'b1;
                    state_next     = arq_pkg::ST_RT_RD;
                end
            end

            arq_pkg::ST_TX_CHK:
            begin
                // Filling free slots in ascending order matches taking the
                // lowest free slot for each queued number.
                if (idx_done || q_stat.empty)
                begin
                    state_next = arq_pkg::ST_DONE_EMIT;
                end
                else if (!slot_valid[slot_idx])
                begin
                    q_ctl.rd_en = 1'b1;
                    state_next  = arq_pkg::ST_TX_EV;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            arq_pkg::ST_TX_EV:
            begin
                if (out_free)
                begin
                    emit               = 1'b1;
                    emit_kind          = arq_pkg::KIND_TRANSMIT;
                    emit_seq           = q_head;
                    slot_wr.seq        = q_head;
                    slot_ctl.wr_en     = 1'b1;
                    slot_ctl.valid_set = 1'b1;
                    q_ctl.pop          = 1'b1;
                    idx_next           = idx_reg + 1'b1;
                    state_next         = arq_pkg::ST_TX_CHK;
                end
            end

            arq_pkg::ST_DONE_EMIT:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    emit_kind  = arq_pkg::KIND_TICK_DONE;
                    state_next = arq_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = arq_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= arq_pkg::ST_IDLE;
            idx_reg       <= '0;
            next_seq_reg  <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            next_seq_reg <= next_seq_next;
            found_reg    <= found_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            ack_reg <= s_axis_tdata[15:0];
            now_reg <= s_axis_tdata[47:16];
        end
        if (emit)
        begin
            out_kind_reg <= emit_kind;
            out_seq_reg  <= emit_seq;
            // Only the scan results can be followed by more of the same request.
            out_last_reg <= (emit_kind != arq_pkg::KIND_TRANSMIT) &&
                            (emit_kind != arq_pkg::KIND_RETRANSMIT);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_seq_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;

    arq_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (q_ctl),
        .push_data (q_push_data),
        .head_data (q_head),
        .stat      (q_stat)
    );

    arq_slots #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_slots (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (slot_ctl),
        .addr    (slot_idx),
        .wr_data (slot_wr),
        .rd_data (slot_rd),
        .valid   (slot_valid)
    );

endmodule

// ===== rtl/arq_checker.sv =====
// ----------------------------------------------------------------------------
// arq_checker
// Port-level checks of the ARQ sender tracker, bound to the top level.
// ----------------------------------------------------------------------------
module arq_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [1:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    // Queue full and tick done carry no sequence number.
    a_zero_seq: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == 3'(arq_pkg::KIND_FULL) ||
                          m_axis_tuser == 3'(arq_pkg::KIND_TICK_DONE))
        |-> (m_axis_tdata == '0))
        else $error("queue full or tick done result carries a sequence number");

    // Scan results never close a request; all other results always do.
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tlast ==
            !(m_axis_tuser == 3'(arq_pkg::KIND_TRANSMIT) ||
              m_axis_tuser == 3'(arq_pkg::KIND_RETRANSMIT))))
        else $error("tlast does not match the result kind");

    // A submit is still being worked on in the following cycle.
    a_submit_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == 2'(arq_pkg::FUNC_SUBMIT))
        |=> !s_axis_tready)
        else $error("new request taken while a submit is pending");

    // A stalled result holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready
        |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
            $stable(m_axis_tlast))
        else $error("stalled result changed");

endmodule

bind arq_sender_tracker arq_checker u_arq_checker (.*);

// ===== tb/sv/arq_tracker_checker.sv =====
// ----------------------------------------------------------------------------
// arq_tracker_checker
// Watches the request, result and configuration channels of the ARQ sender
// tracker, keeps its own copy of the retransmit table, and compares every
// result with the one that copy predicts.
// ----------------------------------------------------------------------------
module arq_tracker_checker
    import arq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int SLOT_COUNT  = DEF_SLOT_COUNT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // [15:0] ack_seq, [47:16] now
    input  logic [1:0]  s_axis_tuser,   // [1:0] func
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata,   // [15:0] seq
    input  logic [2:0]  m_axis_tuser,   // [2:0] kind
    input  logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        end_check,
    output int          mismatch_count,
    output int          pending_count
);

    localparam logic [2:0] TIMEOUT_ADDR = {REG_TIMEOUT, 2'b00};

    typedef struct packed {
        kind_t            kind;
        logic [SEQ_W-1:0] seq;
        logic             last;
    } link_event_t;

    link_event_t owed_events[$];
    link_event_t oldest;
    bit          leftovers_reported;

    // Mirror of the tracker state.
    logic [TIMEOUT_W-1:0] timeout_ticks;
    logic [SEQ_W-1:0]     seq_counter;
    logic [SEQ_W-1:0]     fifo_mem [QUEUE_DEPTH];
    int                   fifo_head;
    int                   fifo_tail;
    int                   fifo_count;
    logic                 slot_busy    [SLOT_COUNT];
    logic [SEQ_W-1:0]     slot_num     [SLOT_COUNT];
    logic [TIME_W-1:0]    slot_sent_at [SLOT_COUNT];

    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 40)
            $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    task automatic owe_event(input kind_t kind, input logic [SEQ_W-1:0] seq,
                             input logic last);
        link_event_t ev;
        ev.kind = kind;
        ev.seq  = seq;
        ev.last = last;
        owed_events.push_back(ev);
    endtask

    // Applies one request to the mirrored table and queues the link events
    // that it must produce.
    task automatic advance_table(input logic [FUNC_W-1:0] func,
                                 input logic [SEQ_W-1:0] ack,
                                 input logic [TIME_W-1:0] tnow);
        bit                hit;
        int                slot;
        logic [TIME_W-1:0] age;
        logic [SEQ_W-1:0]  head_num;
        hit = 1'b0;
        case (func)
            FUNC_SUBMIT:
            begin
                if (fifo_count >= QUEUE_DEPTH)
                begin
                    owe_event(KIND_FULL, '0, 1'b1);
                end
                else
                begin
                    seq_counter = seq_counter + 1'b1;
                    fifo_mem[fifo_tail] = seq_counter;
                    fifo_tail = (fifo_tail + 1) % QUEUE_DEPTH;
                    fifo_count++;
                    owe_event(KIND_ACCEPTED, seq_counter, 1'b1);
                end
            end
            FUNC_ACK:
            begin
                // Only the first matching slot is freed.
                for (int i = 0; i < SLOT_COUNT; i++)
                begin
                    if (!hit && slot_busy[i] && slot_num[i] == ack)
                    begin
                        slot_busy[i] = 1'b0;
                        hit = 1'b1;
                    end
                end
                owe_event(hit ? KIND_ACK_CLEARED : KIND_DUP_ACK, ack, 1'b1);
            end
            FUNC_TICK:
            begin
                for (int i = 0; i < SLOT_COUNT; i++)
                begin
                    age = tnow - slot_sent_at[i];
                    if (slot_busy[i] && age >= TIME_W'(timeout_ticks))
                    begin
                        slot_sent_at[i] = tnow;
                        owe_event(KIND_RETRANSMIT, slot_num[i], 1'b0);
                    end
                end
                while (fifo_count > 0)
                begin
                    slot = -1;
                    for (int i = SLOT_COUNT - 1; i >= 0; i--)
                        if (!slot_busy[i])
                            slot = i;
                    if (slot < 0)
                        break;
                    head_num = fifo_mem[fifo_head];
                    fifo_head = (fifo_head + 1) % QUEUE_DEPTH;
                    fifo_count--;
                    slot_busy[slot]    = 1'b1;
                    slot_num[slot]     = head_num;
                    slot_sent_at[slot] = tnow;
                    owe_event(KIND_TRANSMIT, head_num, 1'b0);
                end
                owe_event(KIND_TICK_DONE, '0, 1'b1);
            end
            default:
            begin
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owed_events.delete();
            leftovers_reported = 1'b0;
            mismatch_count = 0;
            pending_count = 0;
            timeout_ticks = TIMEOUT_RESET;
            seq_counter = '0;
            fifo_head = 0;
            fifo_tail = 0;
            fifo_count = 0;
            for (int i = 0; i < SLOT_COUNT; i++)
                slot_busy[i] = 1'b0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == TIMEOUT_ADDR)
                timeout_ticks = pwdata[TIMEOUT_W-1:0];

            if (s_axis_tvalid && s_axis_tready)
                advance_table(s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[47:16]);

            if (m_axis_tvalid && m_axis_tready)
            begin
                if (owed_events.size() == 0)
                begin
                    flag_mismatch($sformatf("unexpected result kind %0d seq %0d last %0d",
                                            m_axis_tuser, m_axis_tdata, m_axis_tlast));
                end
                else
                begin
                    oldest = owed_events.pop_front();
                    if (m_axis_tuser != oldest.kind || m_axis_tdata != oldest.seq ||
                        m_axis_tlast != oldest.last)
                        flag_mismatch($sformatf(
                            "got kind %0d seq %0d last %0d, want kind %0d seq %0d last %0d",
                            m_axis_tuser, m_axis_tdata, m_axis_tlast,
                            oldest.kind, oldest.seq, oldest.last));
                end
            end

            if (end_check && !leftovers_reported)
            begin
                leftovers_reported = 1'b1;
                if (owed_events.size() != 0)
                    flag_mismatch($sformatf("%0d results never arrived",
                                            owed_events.size()));
            end

            pending_count = owed_events.size();
        end
    end

endmodule

// ===== tb/sv/tb_arq_sender_tracker.sv =====
// ----------------------------------------------------------------------------
// tb_arq_sender_tracker
// Drives submits, acks and ticks into the ARQ sender tracker through its
// request stream, stalls both streams at random, reprograms the timeout
// between phases and lets the checker judge every result.
// ----------------------------------------------------------------------------
module tb_arq_sender_tracker;

    import arq_pkg::*;

    // The tracker does not define func 3; it must swallow such a request.
    localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;

    localparam logic [2:0] TIMEOUT_ADDR = {REG_TIMEOUT, 2'b00};

    // Wait longer than a full tick scan whenever the tracker has to be idle and
    // no result is left to prove it.
    localparam int SETTLE_CYCLES = 4 * DEF_SLOT_COUNT + 20;

    // Length of the one long receiver hold-off that fills the tracker up.
    localparam int LONG_HOLD = 400;

    // A correct run stays well within this limit even when every
    // tick produces its most results under the longest stalls.
    localparam int CYCLE_LIMIT = 200_000;

    logic        clk;
    logic        rst_n = 1'b0;

    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata  = '0;    // [15:0] ack_seq, [47:16] now
    logic [1:0]  s_axis_tuser  = '0;    // [1:0] func

    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;          // [15:0] seq
    logic [2:0]  m_axis_tuser;          // [2:0] kind
    logic        m_axis_tlast;

    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    logic        end_check = 1'b0;
    int          mismatch_count;
    int          pending_count;
    int          cycle_count;

    // Shared between the stimulus and the receiver process.
    bit          no_idle   = 1'b0;
    bit          hold_long = 1'b0;

    // Sequence numbers the tracker has handed out and not yet seen acked.
    // The stimulus uses this list to aim acks at live entries.
    logic [15:0] in_flight[$];
    logic [31:0] cur_time    = '0;

    arq_sender_tracker DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    arq_tracker_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser),
        .m_axis_tlast   (m_axis_tlast),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .end_check      (end_check),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // Result receiver. It mostly accepts, but unless idling is off it drops tready
    // in short random bursts so that stalls land on every step of a scan. When the
    // stimulus raises hold_long it refuses everything for one long hold-off, which
    // backs results up into the tracker until it stops taking requests.
    initial
    begin
        @(posedge clk);
        forever
        begin
            if (hold_long)
            begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_long = 1'b0;
            end
            else if (!no_idle && $urandom_range(0, 2) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
            end
            else
            begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
        end
    end

    // Keeps the list of live sequence numbers from the results themselves.
    always @(posedge clk)
    begin
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (m_axis_tuser == KIND_ACCEPTED)
            begin
                in_flight.push_back(m_axis_tdata);
            end
            else if (m_axis_tuser == KIND_ACK_CLEARED)
            begin
                for (int j = 0; j < in_flight.size(); j++)
                begin
                    if (in_flight[j] == m_axis_tdata)
                    begin
                        in_flight.delete(j);
                        break;
                    end
                end
            end
        end
    end

    // Offers one request and returns at the clock edge that accepts it.
    // A random gap may come first, unless idling is off.
    task automatic send_request(input logic [FUNC_W-1:0] func,
                                input logic [15:0] ack,
                                input logic [31:0] tnow);
        if (!no_idle && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {tnow, ack};
        s_axis_tuser  <= func;
        do
            @(posedge clk);
        while (!(s_axis_tvalid && s_axis_tready));
    endtask

    // Waits until every predicted result has come back, then lets a full
    // scan's worth of cycles go by in case the last request produced nothing.
    task automatic await_idle();
        s_axis_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (pending_count != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // APB write of the timeout register: a setup phase, then an access phase.
    task automatic write_timeout(input logic [7:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= TIMEOUT_ADDR;
        pwdata  <= {24'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Empties the queue and the slots: a tick pulls queued numbers into free
    // slots, then every number still live is acked. A few rounds suffice,
    // since at most SLOT_COUNT numbers move per tick.
    task automatic flush_table();
        logic [15:0] live[$];
        repeat (4)
        begin
            if (in_flight.size() == 0)
                break;
            send_request(FUNC_TICK, $urandom(), cur_time);
            await_idle();
            live = in_flight;
            foreach (live[j])
                send_request(FUNC_ACK, live[j], $urandom());
            await_idle();
        end
    endtask

    // Random traffic shaped like real link use: submits, acks aimed mostly at
    // live numbers, and ticks with a slowly advancing clock that now and then
    // jumps. Stray acks and spare funcs add noise; the spare funcs are not
    // counted because the tracker ignores them.
    task automatic run_random(input int count);
        int          taken;
        int          pick;
        logic [15:0] ack;
        taken = 0;
        while (taken < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
            begin
                send_request(FUNC_SUBMIT, $urandom(), $urandom());
                taken++;
            end
            else if (pick < 60)
            begin
                if (in_flight.size() != 0)
                    ack = in_flight[$urandom_range(0, in_flight.size() - 1)];
                else
                    ack = $urandom_range(0, 65535);
                send_request(FUNC_ACK, ack, $urandom());
                taken++;
            end
            else if (pick < 85)
            begin
                if ($urandom_range(0, 9) == 0)
                    cur_time = $urandom();
                else
                    cur_time = cur_time + $urandom_range(0, 4);
                send_request(FUNC_TICK, $urandom(), cur_time);
                taken++;
            end
            else if (pick < 93)
            begin
                send_request(FUNC_ACK, $urandom_range(0, 65535), $urandom());
                taken++;
            end
            else
            begin
                send_request(FUNC_SPARE, $urandom(), $urandom());
            end
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, with the timeout at its reset value of 2.
        // A spare func with every data bit set must be ignored.
        send_request(FUNC_SPARE, 16'hFFFF, 32'hFFFF_FFFF);
        // Acks with nothing outstanding are duplicates, at both extremes.
        send_request(FUNC_ACK, 16'h0000, 32'h0000_0000);
        send_request(FUNC_ACK, 16'hFFFF, 32'hFFFF_FFFF);
        // A tick on an empty table only closes itself.
        send_request(FUNC_TICK, 16'h0000, 32'h0000_0000);
        // Sixteen submits fill the queue; the seventeenth is refused.
        repeat (17) send_request(FUNC_SUBMIT, 16'hFFFF, 32'hFFFF_FFFF);
        // Everything moves into the slots just below the top of the clock.
        send_request(FUNC_TICK, 16'hFFFF, 32'hFFFF_FFFE);
        // One unit later nothing is old enough yet.
        send_request(FUNC_TICK, 16'h0000, 32'hFFFF_FFFF);
        // The clock wraps to zero: the age is 2 and all slots go out again.
        send_request(FUNC_TICK, 16'h0000, 32'h0000_0000);
        // Clear one entry, ack it again as a duplicate, clear the last one.
        send_request(FUNC_ACK, 16'd1, 32'h0000_0000);
        send_request(FUNC_ACK, 16'd1, 32'h0000_0000);
        send_request(FUNC_ACK, 16'd16, 32'h0000_0000);
        await_idle();

        // With a zero timeout even entries stamped this very moment go out.
        write_timeout(8'd0);
        send_request(FUNC_TICK, 16'h0000, 32'h0000_0000);
        await_idle();
        write_timeout(8'd255);
        flush_table();

        // Random phases, one per timeout setting.
        write_timeout(8'd0);
        cur_time = $urandom();
        run_random(17);
        await_idle();

        // The receiver holds off for a long while as this phase starts, so
        // the tracker backs up and refuses requests for a time.
        write_timeout(8'd255);
        hold_long = 1'b1;
        run_random(17);
        await_idle();

        write_timeout(8'($urandom_range(1, 6)));
        run_random(17);
        await_idle();

        // Last phase runs at full rate on both sides.
        write_timeout(TIMEOUT_RESET + 8'd1);
        no_idle = 1'b1;
        run_random(17);
        await_idle();

        end_check <= 1'b1;
        repeat (2) @(posedge clk);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
